// File: sv/gf2_poly_modular_multiplier_unit_assert.svh
// assertion macros for the gf2 polynomial modular multiplier
`ifndef GF2_POLY_MODULAR_MULTIPLIER_UNIT_ASSERT_SVH
`define GF2_POLY_MODULAR_MULTIPLIER_UNIT_ASSERT_SVH

// checked outside reset, clocked by clock
`define GPMM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define GPMM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/gpmm_pkg.sv
// shared types and constants of the gf2 polynomial modular multiplier
package gpmm_pkg;

   localparam int OPERAND_W  = 64;
   localparam int PRODUCT_W  = 63;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_IDX_LSB = 3;

   localparam logic [CSR_ADDR_W-CSR_IDX_LSB-1:0] REG_MODULUS = 1'b0;
   localparam logic [CSR_DATA_W-1:0] MODULUS_RESET = 64'd283;

   typedef struct packed {
      logic load;
      logic norm_step;
      logic red_step;
      logic mul_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic deg_zero;
      logic norm_done;
      logic red_last;
      logic mul_done;
   } sts_type;

endpackage

// File: sv/gpmm_ctrl.sv
// sequencing state machine of the gf2 polynomial modular multiplier
module gpmm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  gpmm_pkg::sts_type sts,
   output gpmm_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_RED,
      ST_MUL,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (sts.deg_zero) begin
               state_in = ST_FIN;
            end else if (sts.norm_done) begin
               state_in = ST_RED;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_RED: begin
            cmd.red_step = 1'b1;
            if (sts.red_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (sts.mul_done) begin
               state_in = ST_FIN;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/gpmm_dp.sv
// operand registers, normalizer, reducer and shift-and-add accumulator
module gpmm_dp #(
   parameter int POLY_BITS = 64
) (
   input  logic                                clock,
   input  gpmm_pkg::cmd_type                   cmd,
   input  logic [gpmm_pkg::OPERAND_W-1:0]      operand_a,
   input  logic [gpmm_pkg::OPERAND_W-1:0]      operand_b,
   input  logic [gpmm_pkg::CSR_DATA_W-1:0]     modulus,
   output gpmm_pkg::sts_type                   sts,
   output logic [gpmm_pkg::PRODUCT_W-1:0]      product
);

   localparam int DW          = $clog2(POLY_BITS);
   localparam int NORM_STRIDE = 8;

   logic [POLY_BITS-1:0]          a_ff, a_in;
   logic [POLY_BITS-1:0]          b_ff, b_in;
   logic [POLY_BITS-1:0]          m_ff, m_in;
   logic [POLY_BITS-1:0]          ms_ff, ms_in;
   logic [POLY_BITS-1:0]          acc_ff, acc_in;
   logic [DW-1:0]                 deg_ff, deg_in;
   logic [DW-1:0]                 idx_ff, idx_in;
   logic [gpmm_pkg::PRODUCT_W-1:0] prod_ff, prod_in;
   logic [POLY_BITS-1:0]          b_shl;
   logic [gpmm_pkg::OPERAND_W-1:0] acc_ext;

   assign b_shl   = {b_ff[POLY_BITS-2:0], 1'b0};
   assign acc_ext = gpmm_pkg::OPERAND_W'(acc_ff);

   assign sts.deg_zero  = (m_ff[POLY_BITS-1:1] == '0);
   assign sts.norm_done = ms_ff[POLY_BITS-1];
   assign sts.red_last  = (idx_ff == deg_ff);
   assign sts.mul_done  = (a_ff == '0);
   assign product       = prod_ff;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      ms_in   = ms_ff;
      acc_in  = acc_ff;
      deg_in  = deg_ff;
      idx_in  = idx_ff;
      prod_in = prod_ff;
      if (cmd.load) begin
         a_in   = operand_a[POLY_BITS-1:0];
         b_in   = operand_b[POLY_BITS-1:0];
         m_in   = modulus[POLY_BITS-1:0];
         ms_in  = modulus[POLY_BITS-1:0];
         acc_in = '0;
         deg_in = DW'(POLY_BITS - 1);
         idx_in = DW'(POLY_BITS - 1);
      end else if (cmd.norm_step) begin
         // coarse step while a whole byte on top is clear
         if (ms_ff[POLY_BITS-1 -: NORM_STRIDE] == '0) begin
            ms_in  = ms_ff << NORM_STRIDE;
            deg_in = deg_ff - DW'(NORM_STRIDE);
         end else if (!ms_ff[POLY_BITS-1]) begin
            ms_in  = ms_ff << 1;
            deg_in = deg_ff - DW'(1);
         end
      end else if (cmd.red_step) begin
         if (b_ff[idx_ff]) begin
            b_in = b_ff ^ ms_ff;
         end
         ms_in  = ms_ff >> 1;
         idx_in = idx_ff - DW'(1);
      end else if (cmd.mul_step) begin
         if (a_ff[0]) begin
            acc_in = acc_ff ^ b_ff;
         end
         a_in = a_ff >> 1;
         b_in = b_shl[deg_ff] ? (b_shl ^ m_ff) : b_shl;
      end else if (cmd.out_load) begin
         prod_in = sts.deg_zero ? '0 : acc_ext[gpmm_pkg::PRODUCT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      m_ff    <= m_in;
      ms_ff   <= ms_in;
      acc_ff  <= acc_in;
      deg_ff  <= deg_in;
      idx_ff  <= idx_in;
      prod_ff <= prod_in;
   end

endmodule

// File: sv/gf2_poly_modular_multiplier_unit.sv
// top level of the gf2 polynomial modular multiplier with its register port
// Computes operand_a * operand_b modulo the modulus register over GF(2), operands and
// modulus taken POLY_BITS wide. One item is in work at a time; the next one is taken
// while a finished product waits in the output register. With d the modulus degree, an
// item is accepted, the modulus is normalized, operand_b is reduced bit by bit from the
// top down to bit d, operand_a is worked off in shift-and-add steps, one per bit up to
// its highest set bit, plus a last check, and the result is loaded; when the modulus is
// 0 or 1 the product is 0 and the work steps are skipped. The normalizer shifts the
// modulus by a whole byte while its top byte is clear and by one bit otherwise; the
// other steps go one bit at a time. The modulus register sits at byte address 0 of the
// 64-bit register port; writes must come only while idle; the block does not enforce it.
module gf2_poly_modular_multiplier_unit #(
   parameter int POLY_BITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [gpmm_pkg::OPERAND_W-1:0]       req_operand_a,
   input  logic [gpmm_pkg::OPERAND_W-1:0]       req_operand_b,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [gpmm_pkg::PRODUCT_W-1:0]       rsp_product,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gpmm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [gpmm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [gpmm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic [gpmm_pkg::CSR_DATA_W-1:0] modulus_ff, modulus_in;
   logic                            csr_wr;
   logic                            csr_hit;
   gpmm_pkg::cmd_type               cmd;
   gpmm_pkg::sts_type               sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_hit    = (csr_paddr[gpmm_pkg::CSR_ADDR_W-1:gpmm_pkg::CSR_IDX_LSB]
                        == gpmm_pkg::REG_MODULUS);
   assign modulus_in = (csr_wr && csr_hit) ? csr_pwdata : modulus_ff;
   assign csr_prdata = csr_hit ? modulus_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= gpmm_pkg::MODULUS_RESET;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   gpmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gpmm_dp #(
      .POLY_BITS (POLY_BITS)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .modulus   (modulus_ff),
      .sts       (sts),
      .product   (rsp_product)
   );

endmodule

// File: sv/gpmm_checker.sv
// port-level assertions for the gf2 polynomial modular multiplier and their bind
`include "gf2_poly_modular_multiplier_unit_assert.svh"

module gpmm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [gpmm_pkg::PRODUCT_W-1:0]       rsp_product,
   input logic                                 csr_psel,
   input logic                                 csr_penable,
   input logic                                 csr_pwrite,
   input logic [gpmm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input logic [gpmm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input logic [gpmm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input logic                                 csr_pready
);

   logic csr_wr_mod;
   logic csr_rd_mod;

   assign csr_wr_mod = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && !csr_paddr[gpmm_pkg::CSR_IDX_LSB];
   assign csr_rd_mod = !csr_paddr[gpmm_pkg::CSR_IDX_LSB];

   `GPMM_ASSERT_ALWAYS(a_pready_high, csr_pready, "register port not ready")

   // one item in work at a time
   `GPMM_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready,
      "input taken again right after a transfer")

   // a result is only produced after a busy cycle
   `GPMM_ASSERT(a_result_after_work, $rose(rsp_valid) |-> !$past(req_ready),
      "result appeared without work")

   `GPMM_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_product)), "stalled result dropped or changed")

   `GPMM_ASSERT(a_modulus_readback, (csr_wr_mod ##1 csr_rd_mod) |->
      (csr_prdata == $past(csr_pwdata)), "modulus readback mismatch")

endmodule

bind gf2_poly_modular_multiplier_unit gpmm_checker u_gpmm_checker (.*);

// File: tb/sv/gf2_poly_modular_multiplier_unit_checker.sv
// product predictor and scoreboard watching the multiplier channels and register port
`timescale 1ns / 100ps

module gf2_poly_modular_multiplier_unit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [gpmm_pkg::OPERAND_W-1:0]  req_operand_a,
   input  logic [gpmm_pkg::OPERAND_W-1:0]  req_operand_b,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [gpmm_pkg::PRODUCT_W-1:0]  rsp_product,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gpmm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gpmm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                            csr_pready,
   output int                              error_count,
   output int                              outstanding
);

   logic [gpmm_pkg::CSR_DATA_W-1:0] modulus_copy;
   logic [gpmm_pkg::PRODUCT_W-1:0]  pending_products[$];
   int                              mismatches;

   // carry-less product of a and b reduced modulo m
   function automatic logic [gpmm_pkg::PRODUCT_W-1:0] gf2_mulmod(
      input logic [gpmm_pkg::OPERAND_W-1:0] a,
      input logic [gpmm_pkg::OPERAND_W-1:0] b,
      input logic [gpmm_pkg::OPERAND_W-1:0] m);
      logic [gpmm_pkg::OPERAND_W-1:0] acc;
      logic [gpmm_pkg::OPERAND_W-1:0] running;
      int                             deg;
      int                             i;
      deg = 0;
      for (i = 0; i < gpmm_pkg::OPERAND_W; i++) begin
         if (m[i]) deg = i;
      end
      if (deg == 0) return '0;
      running = b;
      for (i = gpmm_pkg::OPERAND_W - 1; i >= deg; i--) begin
         if (running[i]) running ^= m << (i - deg);
      end
      acc = '0;
      for (i = 0; i < gpmm_pkg::OPERAND_W; i++) begin
         if (a[i]) acc ^= running;
         running = running << 1;
         if (running[deg]) running ^= m;
      end
      return acc[gpmm_pkg::PRODUCT_W-1:0];
   endfunction

   always @(posedge clock) begin
      logic [gpmm_pkg::PRODUCT_W-1:0] want;
      if (reset) begin
         modulus_copy = gpmm_pkg::MODULUS_RESET;
         pending_products.delete();
      end else begin
         if (req_valid && req_ready) begin
            pending_products.push_back(gf2_mulmod(req_operand_a, req_operand_b,
                                                  modulus_copy));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[gpmm_pkg::CSR_ADDR_W-1:gpmm_pkg::CSR_IDX_LSB] ==
             gpmm_pkg::REG_MODULUS) begin
            modulus_copy = csr_pwdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_products.size() == 0) begin
               $display("%0t: product transfer with none pending: expected none, actual %h",
                        $time, rsp_product);
               mismatches++;
            end else begin
               want = pending_products.pop_front();
               if (rsp_product !== want) begin
                  $display("%0t: product mismatch: expected %h, actual %h",
                           $time, want, rsp_product);
                  mismatches++;
               end
            end
         end
      end
      outstanding <= pending_products.size();
      error_count <= mismatches;
   end

endmodule

// File: tb/sv/gf2_poly_modular_multiplier_unit_test.sv
// stimulus, idling, watchdog and verdict for the gf2 polynomial modular multiplier
`timescale 1ns / 100ps

module gf2_poly_modular_multiplier_unit_test;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 48;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [gpmm_pkg::OPERAND_W-1:0]  req_operand_a;
   logic [gpmm_pkg::OPERAND_W-1:0]  req_operand_b;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [gpmm_pkg::PRODUCT_W-1:0]  rsp_product;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [gpmm_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [gpmm_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [gpmm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   int error_count;
   int outstanding;
   int src_stall_pct;
   int sink_stall_pct;
   int sink_stall_left;
   int idle_cycles;

   gf2_poly_modular_multiplier_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_product   (rsp_product),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   gf2_poly_modular_multiplier_unit_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_product   (rsp_product),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .outstanding   (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (reset || sink_stall_pct == 0) begin
         sink_stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (sink_stall_left > 0) begin
         sink_stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
         sink_stall_left = $urandom_range(1, 19) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [gpmm_pkg::OPERAND_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [gpmm_pkg::OPERAND_W-1:0] rand_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(0, 63);
         3: return rand_word() >> $urandom_range(1, 63);
         default: return rand_word();
      endcase
   endfunction

   function automatic logic [gpmm_pkg::CSR_DATA_W-1:0] rand_modulus();
      int deg;
      case ($urandom_range(0, 11))
         0: return '0;
         1: return 64'd1;
         2: return gpmm_pkg::MODULUS_RESET;
         3: return '1;
         4: return 64'd2;
         5: return (64'd1 << 63) | 64'd1;
         default: begin
            deg = $urandom_range(1, 63);
            return (rand_word() & ((64'd1 << deg) - 1)) | (64'd1 << deg);
         end
      endcase
   endfunction

   // one operand transfer, with an optional gap before it
   task automatic send_operands(input logic [gpmm_pkg::OPERAND_W-1:0] a,
                                input logic [gpmm_pkg::OPERAND_W-1:0] b);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < src_stall_pct) gap = $urandom_range(1, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // lower valid after the last transfer and wait for every product
   task automatic drain_products();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [gpmm_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= gpmm_pkg::CSR_ADDR_W'(gpmm_pkg::REG_MODULUS) << gpmm_pkg::CSR_IDX_LSB;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_extremes(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         case (i)
            0: send_operands('1, '1);
            1: send_operands(64'd1 << 63, 64'd1 << 63);
            2: send_operands('0, '1);
            3: send_operands(64'd1, '1);
            4: send_operands('1, 64'd1);
            5: send_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
            6: send_operands(64'd1 << 63, '0);
            default: send_operands(rand_word(), rand_word());
         endcase
      end
   endtask

   initial begin
      int phase;
      int n;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_operand_a  <= '0;
      req_operand_b  <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      src_stall_pct  = 20;
      sink_stall_pct = 20;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes under the reset modulus, then the degree-zero and degree-63 moduli
      send_extremes(8);
      drain_products();
      write_modulus('0);
      send_extremes(4);
      drain_products();
      write_modulus(64'd1);
      send_extremes(4);
      drain_products();
      write_modulus((64'd1 << 63) | 64'h1B);
      send_extremes(4);
      drain_products();
      write_modulus('1);
      send_extremes(4);
      drain_products();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_modulus(rand_modulus());
         if (phase == RANDOM_PHASES - 1) begin
            src_stall_pct  = 0;
            sink_stall_pct = 0;
         end else begin
            src_stall_pct  = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 60);
            sink_stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 60);
         end
         for (n = 0; n < PHASE_ITEMS; n++) send_operands(rand_operand(), rand_operand());
         drain_products();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
